>>> rtl/dtp_pkg.sv
// Shared types, character codes and month name tables for the date text parser.
package dtp_pkg;

    // Default longest month name that the name buffer holds
    localparam int NAME_LEN_DEFAULT = 9;

    // Number of parallel number readers and their roles
    localparam int NUM_READERS = 7;
    localparam int RD_SMON     = 0;
    localparam int RD_SDAY     = 1;
    localparam int RD_SYEAR    = 2;
    localparam int RD_TDAY     = 3;
    localparam int RD_TYEAR    = 4;
    localparam int RD_CDAY     = 5;
    localparam int RD_CYEAR    = 6;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Numeric limits and markers
    localparam logic [15:0] NUM_MAX    = 16'hFFFF;
    localparam logic [3:0]  INDEX_NONE = 4'hF;
    localparam logic [3:0]  SHORT_SPACE_INDEX = 4'd3;
    localparam int          SHORT_LEN  = 3;

    // Month names, left aligned and padded with spaces to nine characters
    localparam int MONTH_CHARS = 9;
    localparam logic [8*MONTH_CHARS-1:0] MONTH_TEXT [12] = '{
        "January  ", "February ", "March    ", "April    ",
        "May      ", "June     ", "July     ", "August   ",
        "September", "October  ", "November ", "December "
    };
    localparam logic [3:0] MONTH_LENS [12] = '{
        4'd7, 4'd8, 4'd5, 4'd5, 4'd3, 4'd4, 4'd4, 4'd6, 4'd9, 4'd7, 4'd8, 4'd8
    };

    // Detected format
    typedef enum logic [1:0] {
        FMT_NONE  = 2'd0,
        FMT_FULL  = 2'd1,
        FMT_SLASH = 2'd2,
        FMT_SHORT = 2'd3
    } t_fmt;

    // Parse status
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FORMAT  = 2'd1,
        ST_BAD_MONTH  = 2'd2,
        ST_NO_NUMBER  = 2'd3
    } t_status;

    // Input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [15:0] year_value;
        logic [15:0] month_value;
        logic [15:0] day_value;
        logic [1:0]  date_format;
        logic [1:0]  parse_status;
    } t_out_item;

    // Per-reader control for one character step
    typedef struct packed {
        logic advance;
        logic clear;
        logic feed;
        logic start;
        logic stop;
    } t_rd_ctl;

endpackage

>>> rtl/dtp_reader.sv
// One decimal number reader: skips white space, takes a sign, accumulates digits.
module dtp_reader #(
    parameter bit START_ACTIVE = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dtp_pkg::t_rd_ctl i_ctl,
    input  logic [7:0]       i_char,
    output logic [15:0]      o_num,
    output logic             o_has
);
    import dtp_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_LEAD   = 5'b00010,
        PH_SIGN   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    localparam t_phase PH_RESET = START_ACTIVE ? PH_LEAD : PH_IDLE;

    t_phase      r_phase, n_phase;
    logic [15:0] r_value, n_value;
    logic        r_has, n_has;
    logic        r_minus, n_minus;

    logic        is_digit;
    logic        is_ws;
    logic [3:0]  digit;
    logic [19:0] acc;

    assign is_digit = (i_char >= CH_0) && (i_char <= CH_9);
    assign is_ws    = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign digit    = 4'(i_char - CH_0);
    // value * 10 + digit, 20 bits hold the largest case
    assign acc      = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1) + {16'b0, digit};

    // Phase and value update for one character
    always_comb begin
        n_phase = r_phase;
        n_value = r_value;
        n_has   = r_has;
        n_minus = r_minus;
        if (i_ctl.feed) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (is_ws) begin
                        n_phase = PH_LEAD;
                    end else if (i_char == CH_PLUS || i_char == CH_MINUS) begin
                        n_phase = PH_SIGN;
                        if (i_char == CH_MINUS) n_minus = 1'b1;
                    end else if (is_digit) begin
                        n_phase = PH_DIGITS;
                        n_value = {12'b0, digit};
                        n_has   = 1'b1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_SIGN: begin
                    if (is_digit) begin
                        n_phase = PH_DIGITS;
                        n_value = {12'b0, digit};
                        n_has   = 1'b1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        n_value = (acc > {4'b0, NUM_MAX}) ? NUM_MAX : acc[15:0];
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_IDLE, PH_DONE: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end else if (i_ctl.start) begin
            if (r_phase == PH_IDLE) n_phase = PH_LEAD;
        end else if (i_ctl.stop) begin
            if (r_phase != PH_IDLE) n_phase = PH_DONE;
        end
    end

    // State registers, cleared after each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RESET;
            r_value <= '0;
            r_has   <= 1'b0;
            r_minus <= 1'b0;
        end else if (i_ctl.advance) begin
            if (i_ctl.clear) begin
                r_phase <= PH_RESET;
                r_value <= '0;
                r_has   <= 1'b0;
                r_minus <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_value <= n_value;
                r_has   <= n_has;
                r_minus <= n_minus;
            end
        end
    end

    // Reading as it stands after this character; a negative reading gives 0
    assign o_has = n_has;
    assign o_num = (n_has && !n_minus) ? n_value : '0;

    // A digit was taken only on the way into the digit phase
    a_has_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has |-> (r_phase == PH_DIGITS || r_phase == PH_DONE))
        else $error("reader holds a digit outside the digit or done phase");

endmodule

>>> rtl/dtp_month_lookup.sv
// Compares the first token with the full or three-letter month names.
module dtp_month_lookup #(
    parameter int NAME_LEN = dtp_pkg::NAME_LEN_DEFAULT,
    parameter int TLW      = $clog2(NAME_LEN + 2)
) (
    input  logic [NAME_LEN-1:0][7:0] i_token,
    input  logic [TLW-1:0]           i_token_len,
    input  logic                     i_full,
    output logic [3:0]               o_month
);
    import dtp_pkg::*;

    // Characters that can be compared at all
    localparam int MAX_CMP = (NAME_LEN < MONTH_CHARS) ? NAME_LEN : MONTH_CHARS;

    // Walk the table from the end so the lowest match wins
    always_comb begin
        int   len;
        logic hit;
        o_month = '0;
        for (int m = 11; m >= 0; m--) begin
            len = i_full ? int'(MONTH_LENS[m]) : SHORT_LEN;
            hit = (len <= NAME_LEN) && (int'(i_token_len) == len);
            for (int i = 0; i < MAX_CMP; i++) begin
                if (i < len && i_token[i] != MONTH_TEXT[m][8*(MONTH_CHARS-i)-1 -: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) o_month = 4'(m + 1);
        end
    end

endmodule

>>> rtl/date_text_parser_core.sv
// Date text parser top level: character intake, parse state and result register.
// The block takes one character of a date string per cycle and gives one result
// item per string once the character flagged last is accepted, through the input
// and result registers, back to back with the next string. Throughput is one
// character per cycle, set by the seven decimal readers (multiply by ten, add,
// saturate) that run side by side, plus the month name compare on the last
// character. An input register and a result register part the two channels, so
// input is only held off while a finished result waits and the item in the
// input register is itself a last character. Commas select the full-name form,
// otherwise slashes the numeric form, otherwise a first space at index 3 the
// short-name form; numbers saturate at 65535 and an unknown name gives month 0.
module date_text_parser_core #(
    parameter int NAME_LEN = dtp_pkg::NAME_LEN_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dtp_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output dtp_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import dtp_pkg::*;

    localparam int TLW = $clog2(NAME_LEN + 2);
    localparam int IW  = $clog2(NAME_LEN);

    // Input and output registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic adv;
    logic adv_last;
    logic [7:0] c;

    // Parse state
    logic [3:0]                r_char_index, n_char_index;
    logic [NAME_LEN-1:0][7:0]  r_token, n_token;
    logic [TLW-1:0]            r_token_len, n_token_len;
    logic [3:0]                r_first_space, n_first_space;
    logic                      r_comma_seen, n_comma_seen;
    logic                      r_slash_seen, n_slash_seen;
    logic [1:0]                r_slash_idx, n_slash_idx;
    logic [1:0]                r_space_idx, n_space_idx;
    logic [1:0]                r_comma_idx, n_comma_idx;

    t_rd_ctl     rd_ctl [NUM_READERS];
    logic [15:0] rd_num [NUM_READERS];
    logic        rd_has [NUM_READERS];
    logic [3:0]  month_code;

    assign c = r_in.char_code;

    // Handshake: the input register moves on unless its last character
    // would overwrite a result that is still waiting
    assign adv        = r_in_valid && (!r_in.last_char || !r_out_valid || !i_out_stall);
    assign adv_last   = adv && r_in.last_char;
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    // Reader controls for this character
    always_comb begin
        for (int g = 0; g < NUM_READERS; g++) begin
            rd_ctl[g] = '{advance: adv, clear: adv_last, feed: 1'b0, start: 1'b0,
                          stop: 1'b0};
        end
        // slash fields: feed the current one, a slash opens the next
        rd_ctl[RD_SMON].feed   = (r_slash_idx == 2'd0);
        rd_ctl[RD_SDAY].feed   = (r_slash_idx == 2'd1);
        rd_ctl[RD_SYEAR].feed  = (r_slash_idx == 2'd2);
        rd_ctl[RD_SDAY].start  = (c == CH_SLASH) && (r_slash_idx == 2'd0);
        rd_ctl[RD_SYEAR].start = (c == CH_SLASH) && (r_slash_idx == 2'd1);
        // space and comma fields
        if (r_space_idx == 2'd0) begin
            if (c == CH_SPACE) begin
                rd_ctl[RD_TDAY].start = 1'b1;
                rd_ctl[RD_CDAY].start = 1'b1;
            end
        end else begin
            if (r_space_idx == 2'd1) begin
                if (c == CH_SPACE) begin
                    rd_ctl[RD_TDAY].stop   = 1'b1;
                    rd_ctl[RD_TYEAR].start = 1'b1;
                end else begin
                    rd_ctl[RD_TDAY].feed = 1'b1;
                end
            end else begin
                rd_ctl[RD_TYEAR].feed = 1'b1;
            end
            if (r_comma_idx == 2'd1) begin
                if (c == CH_COMMA) begin
                    rd_ctl[RD_CDAY].stop   = 1'b1;
                    rd_ctl[RD_CYEAR].start = 1'b1;
                end else begin
                    rd_ctl[RD_CDAY].feed = 1'b1;
                end
            end else begin
                rd_ctl[RD_CYEAR].feed = 1'b1;
            end
        end
    end

    // Number readers
    for (genvar g = 0; g < NUM_READERS; g++) begin : g_reader
        dtp_reader #(
            .START_ACTIVE(g == RD_SMON)
        ) u_reader (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (rd_ctl[g]),
            .i_char  (c),
            .o_num   (rd_num[g]),
            .o_has   (rd_has[g])
        );
    end

    // Token, delimiter and field index update
    always_comb begin
        n_char_index  = (r_char_index < INDEX_NONE) ? r_char_index + 4'd1 : r_char_index;
        n_token       = r_token;
        n_token_len   = r_token_len;
        n_first_space = r_first_space;
        n_comma_seen  = r_comma_seen || (c == CH_COMMA);
        n_slash_seen  = r_slash_seen || (c == CH_SLASH);
        n_slash_idx   = ((c == CH_SLASH) && (r_slash_idx < 2'd2)) ? r_slash_idx + 2'd1
                                                                   : r_slash_idx;
        n_space_idx   = r_space_idx;
        n_comma_idx   = r_comma_idx;
        if (r_space_idx == 2'd0) begin
            if (c == CH_SPACE) begin
                n_first_space = r_char_index;
                n_space_idx   = 2'd1;
                n_comma_idx   = 2'd1;
            end else begin
                if (int'(r_token_len) < NAME_LEN) n_token[r_token_len[IW-1:0]] = c;
                if (int'(r_token_len) <= NAME_LEN) n_token_len = r_token_len + TLW'(1);
            end
        end else begin
            if (r_space_idx == 2'd1 && c == CH_SPACE) n_space_idx = 2'd2;
            if (r_comma_idx == 2'd1 && c == CH_COMMA) n_comma_idx = 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || adv_last) begin
            r_char_index  <= '0;
            r_token       <= '0;
            r_token_len   <= '0;
            r_first_space <= INDEX_NONE;
            r_comma_seen  <= 1'b0;
            r_slash_seen  <= 1'b0;
            r_slash_idx   <= '0;
            r_space_idx   <= '0;
            r_comma_idx   <= '0;
        end else if (adv) begin
            r_char_index  <= n_char_index;
            r_token       <= n_token;
            r_token_len   <= n_token_len;
            r_first_space <= n_first_space;
            r_comma_seen  <= n_comma_seen;
            r_slash_seen  <= n_slash_seen;
            r_slash_idx   <= n_slash_idx;
            r_space_idx   <= n_space_idx;
            r_comma_idx   <= n_comma_idx;
        end
    end

    // Month name compare on the token as it stands after this character
    dtp_month_lookup #(
        .NAME_LEN (NAME_LEN),
        .TLW      (TLW)
    ) u_month (
        .i_token     (n_token),
        .i_token_len (n_token_len),
        .i_full      (n_comma_seen),
        .o_month     (month_code)
    );

    // Result assembly
    always_comb begin
        t_fmt    fmt;
        t_status status;
        logic    missing;
        n_out   = '0;
        fmt     = FMT_NONE;
        missing = 1'b0;
        if (n_comma_seen) begin
            fmt               = FMT_FULL;
            n_out.month_value = {12'b0, month_code};
            n_out.day_value   = rd_num[RD_CDAY];
            n_out.year_value  = rd_num[RD_CYEAR];
            missing           = !rd_has[RD_CDAY] || !rd_has[RD_CYEAR];
        end else if (n_slash_seen) begin
            fmt               = FMT_SLASH;
            n_out.month_value = rd_num[RD_SMON];
            n_out.day_value   = rd_num[RD_SDAY];
            n_out.year_value  = rd_num[RD_SYEAR];
            missing           = !rd_has[RD_SMON] || !rd_has[RD_SDAY] || !rd_has[RD_SYEAR];
        end else if (n_first_space == SHORT_SPACE_INDEX) begin
            fmt               = FMT_SHORT;
            n_out.month_value = {12'b0, month_code};
            n_out.day_value   = rd_num[RD_TDAY];
            n_out.year_value  = rd_num[RD_TYEAR];
            missing           = !rd_has[RD_TDAY] || !rd_has[RD_TYEAR];
        end
        if (fmt == FMT_NONE) begin
            status = ST_NO_FORMAT;
        end else if (fmt != FMT_SLASH && month_code == 4'd0) begin
            status = ST_BAD_MONTH;
        end else if (missing) begin
            status = ST_NO_NUMBER;
        end else begin
            status = ST_OK;
        end
        n_out.date_format  = fmt;
        n_out.parse_status = status;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Input is held off only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in.last_char && r_out_valid && i_out_stall))
        else $error("input stalled without a waiting result");

    // A last character always lands a result in the next cycle
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_last |=> o_out_valid)
        else $error("last character did not produce a result");

    // Parse state starts over after each string
    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_last |=> (r_char_index == 4'd0 && r_space_idx == 2'd0 && !r_comma_seen))
        else $error("parse state not cleared after a string");

    // The slash field index never passes the year field
    a_slash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slash_idx != 2'd3)
        else $error("slash field index out of range");

endmodule
